// ----- rtl/core/nth_root_bisection_top_assert.svh -----
// Assertion macros shared by the nth root bisection RTL.
`ifndef NTH_ROOT_BISECTION_TOP_ASSERT_SVH
`define NTH_ROOT_BISECTION_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define NRB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nrb: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define NRB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nrb: next-cycle check failed");

`endif

// ----- rtl/core/nrb_pkg.sv -----
// Package with the microcode format, program and datapath constants.
`default_nettype none

package nrb_pkg;

  localparam int unsigned PC_W      = 4;
  localparam int unsigned RAD_W     = 32;
  localparam int unsigned EXP_W     = 4;
  localparam int unsigned TOL_W     = 31;
  localparam int unsigned BND_W     = 34;
  localparam int unsigned POW_W     = 48;
  localparam int unsigned HALF_W    = 24;
  localparam int unsigned MA_W      = 25;
  localparam int unsigned PROD_W    = 57;
  localparam int unsigned FULL_W    = 80;

  localparam logic [PC_W-1:0] STEP_DONE = 4'd0;
  localparam logic [PC_W-1:0] STEP_IDLE = 4'd1;
  localparam logic [PC_W-1:0] STEP_CHK  = 4'd2;
  localparam logic [PC_W-1:0] STEP_MID  = 4'd3;
  localparam logic [PC_W-1:0] STEP_LOOP = 4'd4;
  localparam logic [PC_W-1:0] STEP_MLO  = 4'd5;
  localparam logic [PC_W-1:0] STEP_MHI  = 4'd6;
  localparam logic [PC_W-1:0] STEP_ACC  = 4'd7;
  localparam logic [PC_W-1:0] STEP_CMP  = 4'd8;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_DONE,
    OP_IDLE,
    OP_CHK,
    OP_MID,
    OP_LOOP,
    OP_MLO,
    OP_MHI,
    OP_ACC,
    OP_CMP
  } op_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_IN_IDLE,
    COND_GAP_OK,
    COND_CNT_ZERO,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic gap_ok;
    logic cnt_zero;
    logic out_busy;
  } flags_t;

  // A taken condition jumps to the target; otherwise the program falls through.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      STEP_DONE: w = '{op: OP_DONE, cond: COND_OUT_BUSY, target: STEP_DONE};
      STEP_IDLE: w = '{op: OP_IDLE, cond: COND_IN_IDLE,  target: STEP_IDLE};
      STEP_CHK:  w = '{op: OP_CHK,  cond: COND_GAP_OK,   target: STEP_DONE};
      STEP_MID:  w = '{op: OP_MID,  cond: COND_NONE,     target: STEP_MID};
      STEP_LOOP: w = '{op: OP_LOOP, cond: COND_CNT_ZERO, target: STEP_CMP};
      STEP_MLO:  w = '{op: OP_MLO,  cond: COND_NONE,     target: STEP_MLO};
      STEP_MHI:  w = '{op: OP_MHI,  cond: COND_NONE,     target: STEP_MHI};
      STEP_ACC:  w = '{op: OP_ACC,  cond: COND_ALWAYS,   target: STEP_LOOP};
      STEP_CMP:  w = '{op: OP_CMP,  cond: COND_ALWAYS,   target: STEP_CHK};
      default:   w = '{op: OP_NOP,  cond: COND_ALWAYS,   target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nrb_if.sv -----
// Valid/ready channel interfaces for the input and result transactions.
`default_nettype none

interface nrb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] radicand;
  logic        [3:0]  exponent;

  modport source (output valid, output radicand, output exponent, input ready);
  modport sink   (input valid, input radicand, input exponent, output ready);
endinterface

interface nrb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] root_value;
  logic               no_real_root;

  modport source (output valid, output root_value, output no_real_root, input ready);
  modport sink   (input valid, input root_value, input no_real_root, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/nth_root_bisection_top.sv -----
// Top level of the fixed-point nth root by bisection, datapath and sequencer.
//
// Computes the exponent-th root of a signed Q16.16 radicand by bisection between
// -max(|x|, 1.0) and +max(|x|, 1.0), one transaction at a time. In each bisection pass,
// every fixed-point multiply runs as two 25x32 partial products on one shared multiplier
// plus a combine and saturate step, n times, where n is the clamped exponent. The number
// of passes is at most 32 and shrinks as the tolerance grows. A new radicand is taken
// while the previous result still waits in the output register.
`default_nettype none

module nth_root_bisection_top #(
  parameter int unsigned MaxExponent = 15,
  parameter int unsigned FracBits    = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [30:0] cfg_wdata_i,
  nrb_in_if.sink           in_i,
  nrb_out_if.source        out_o
);
  import nrb_pkg::*;

  localparam int unsigned CntW = $clog2(MaxExponent + 1);

  localparam logic signed [FULL_W-1:0] PowMax = FULL_W'(48'sh7FFF_FFFF_FFFF);
  localparam logic signed [FULL_W-1:0] PowMin = -(FULL_W'(48'sh7FFF_FFFF_FFFF)) - FULL_W'(1);

  ucode_t ucode;
  flags_t flags;

  logic [TOL_W-1:0]         tol_q;
  logic                     out_valid_q;
  logic signed [RAD_W-1:0]  out_root_q;
  logic                     out_nrr_q;

  logic signed [RAD_W-1:0]  x_q;
  logic [CntW-1:0]          n_q;
  logic [CntW-1:0]          cnt_q;
  logic                     nrr_q;
  logic signed [BND_W-1:0]  lo_q;
  logic signed [BND_W-1:0]  hi_q;
  logic signed [RAD_W-1:0]  mid_q;
  logic signed [POW_W-1:0]  p_q;
  logic signed [PROD_W-1:0] m_q;
  logic signed [PROD_W-1:0] acc_q;

  logic [TOL_W-1:0]         tol_eff;
  logic signed [BND_W-1:0]  gap;
  logic signed [BND_W-1:0]  one_b;
  logic signed [BND_W-1:0]  x_ext;
  logic signed [BND_W-1:0]  x_abs;
  logic signed [BND_W-1:0]  bound;
  logic [CntW-1:0]          n_in;
  logic signed [BND_W-1:0]  sum_b;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [FULL_W-1:0] full;
  logic signed [FULL_W-1:0] shifted;
  logic signed [POW_W-1:0]  p_sat;
  logic                     out_busy;

  nrb_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ucode_o (ucode)
  );

  always_comb begin
    tol_eff  = (tol_q == '0) ? TOL_W'(1) : tol_q;
    gap      = hi_q - lo_q;
    one_b    = BND_W'(1) <<< FracBits;
    x_ext    = BND_W'(in_i.radicand);
    x_abs    = x_ext[BND_W-1] ? -x_ext : x_ext;
    bound    = (x_abs > one_b) ? x_abs : one_b;
    n_in     = (32'(in_i.exponent) > MaxExponent) ? CntW'(MaxExponent)
                                                  : CntW'(in_i.exponent);
    sum_b    = lo_q + hi_q;
    mul_a    = (ucode.op == OP_MHI) ? {p_q[POW_W-1], p_q[POW_W-1:HALF_W]}
                                    : {1'b0, p_q[HALF_W-1:0]};
    mul_p    = PROD_W'(mul_a) * PROD_W'(mid_q);
    full     = FULL_W'(acc_q) + (FULL_W'(m_q) <<< HALF_W);
    shifted  = full >>> FracBits;
    if (shifted > PowMax) begin
      p_sat = PowMax[POW_W-1:0];
    end else if (shifted < PowMin) begin
      p_sat = PowMin[POW_W-1:0];
    end else begin
      p_sat = shifted[POW_W-1:0];
    end
    out_busy = out_valid_q && !out_o.ready;
  end

  always_comb begin
    flags.in_valid = in_i.valid;
    flags.gap_ok   = $unsigned(gap) <= BND_W'(tol_eff);
    flags.cnt_zero = (cnt_q == '0);
    flags.out_busy = out_busy;
  end

  assign in_i.ready = (ucode.op == OP_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= TOL_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      if (ucode.op == OP_DONE && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ucode.op)
      OP_IDLE: begin
        if (in_i.valid) begin
          x_q   <= in_i.radicand;
          n_q   <= n_in;
          nrr_q <= in_i.radicand[RAD_W-1] && !n_in[0];
          lo_q  <= -bound;
          hi_q  <= bound;
          mid_q <= '0;
        end
      end
      OP_MID: begin
        mid_q <= sum_b[RAD_W:1];
        p_q   <= POW_W'(1) <<< FracBits;
        cnt_q <= n_q;
      end
      OP_MLO: begin
        m_q <= mul_p;
      end
      OP_MHI: begin
        acc_q <= m_q;
        m_q   <= mul_p;
      end
      OP_ACC: begin
        p_q   <= p_sat;
        cnt_q <= cnt_q - CntW'(1);
      end
      OP_CMP: begin
        if (p_q < POW_W'(x_q)) begin
          lo_q <= BND_W'(mid_q);
        end else begin
          hi_q <= BND_W'(mid_q);
        end
      end
      OP_DONE: begin
        if (!out_busy) begin
          out_root_q <= mid_q;
          out_nrr_q  <= nrr_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.root_value   = out_root_q;
  assign out_o.no_real_root = out_nrr_q;

`include "nth_root_bisection_top_assert.svh"

  `NRB_ASSERT_IMP(a_bounds_ordered, ucode.op != OP_IDLE, lo_q < hi_q)
  `NRB_ASSERT_NXT(a_accept_starts, in_i.valid && in_i.ready, ucode.op == OP_CHK)
  `NRB_ASSERT_IMP(a_mul_needs_count, ucode.op == OP_MLO, cnt_q != '0)

endmodule

`default_nettype wire

// ----- rtl/core/nrb_sequencer.sv -----
// Microcode sequencer: step counter, program ROM and conditional jumps.
`default_nettype none

module nrb_sequencer (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire nrb_pkg::flags_t flags_i,
  output nrb_pkg::ucode_t      ucode_o
);
  import nrb_pkg::*;

  logic [PC_W-1:0] pc_q;
  logic [PC_W-1:0] pc_d;
  ucode_t          word;
  logic            taken;

  always_comb begin
    word = ucode_rom(pc_q);
    unique case (word.cond)
      COND_NONE:     taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_IN_IDLE:  taken = !flags_i.in_valid;
      COND_GAP_OK:   taken = flags_i.gap_ok;
      COND_CNT_ZERO: taken = flags_i.cnt_zero;
      COND_OUT_BUSY: taken = flags_i.out_busy;
      default:       taken = 1'b1;
    endcase
    pc_d = taken ? word.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ucode_o = word;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the fixed-point nth root by bisection block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nrb_pkg::*;

  localparam int unsigned MaxExponent   = 15;
  localparam int unsigned FracBits      = 16;
  localparam longint      FixedOne      = longint'(1) <<< FracBits;
  localparam longint      PowMax        = (longint'(1) <<< 47) - 1;
  localparam longint      PowMin        = -(longint'(1) <<< 47);
  localparam int unsigned StallLimit    = 20000;
  localparam int unsigned HoldOffCycles = 4000;
  localparam int unsigned PhaseItems    = 130;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned NumDirected   = 24;

  localparam logic [TOL_W-1:0] TolOne  = 31'd1;
  localparam logic [TOL_W-1:0] TolZero = 31'd0;
  localparam logic [TOL_W-1:0] TolMax  = 31'h7FFF_FFFF;
  localparam logic [TOL_W-1:0] TolQ    = 31'h0001_0000;

  typedef struct packed {
    logic signed [RAD_W-1:0] root_value;
    logic                    no_real_root;
  } root_t;

  typedef struct packed {
    logic        [TOL_W-1:0] tol;
    logic signed [RAD_W-1:0] radicand;
    logic        [EXP_W-1:0] exponent;
    logic                    typed;
    logic signed [RAD_W-1:0] root;
    logic                    no_root;
  } dir_row_t;

  typedef enum logic [1:0] {
    SHAPE_FULL,
    SHAPE_SMALL,
    SHAPE_WHOLE,
    SHAPE_EDGE
  } radicand_shape_e;

  localparam logic signed [RAD_W-1:0] EdgeValues [4] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000
  };

  dir_row_t directed_rows [NumDirected] = '{
    '{TolOne,  32'h0000_0000, 4'd1,  1'b0, 32'h0, 1'b0},
    '{TolOne,  32'h7FFF_FFFF, 4'd1,  1'b0, 32'h0, 1'b0},
    '{TolOne,  32'h8000_0000, 4'd1,  1'b0, 32'h0, 1'b0},
    '{TolOne,  32'h8000_0000, 4'd2,  1'b0, 32'h0, 1'b0},
    '{TolOne,  32'h7FFF_FFFF, 4'd15, 1'b0, 32'h0, 1'b0},
    '{TolOne,  32'h8000_0000, 4'd15, 1'b0, 32'h0, 1'b0},
    '{TolOne,  32'h0001_0000, 4'd15, 1'b0, 32'h0, 1'b0},
    '{TolOne,  32'hFFFF_0000, 4'd3,  1'b0, 32'h0, 1'b0},
    '{TolOne,  32'h0000_0001, 4'd2,  1'b0, 32'h0, 1'b0},
    '{TolOne,  32'hFFFF_FFFF, 4'd4,  1'b0, 32'h0, 1'b0},
    '{TolOne,  32'h0004_0000, 4'd2,  1'b0, 32'h0, 1'b0},
    '{TolOne,  32'h0008_0000, 4'd3,  1'b0, 32'h0, 1'b0},
    '{TolOne,  32'h0010_0000, 4'd0,  1'b0, 32'h0, 1'b0},
    '{TolOne,  32'hFFF0_0000, 4'd0,  1'b0, 32'h0, 1'b0},
    '{TolOne,  32'h1234_5678, 4'd7,  1'b0, 32'h0, 1'b0},
    '{TolOne,  32'hEDCB_A988, 4'd9,  1'b0, 32'h0, 1'b0},
    '{TolZero, 32'h0002_0000, 4'd2,  1'b0, 32'h0, 1'b0},
    '{TolZero, 32'hFFFE_0000, 4'd5,  1'b0, 32'h0, 1'b0},
    '{TolMax,  32'h0000_0000, 4'd5,  1'b1, 32'h0, 1'b0},
    '{TolMax,  32'hFFFF_0000, 4'd2,  1'b1, 32'h0, 1'b1},
    '{TolMax,  32'h3FFF_0000, 4'd3,  1'b1, 32'h0, 1'b0},
    '{TolMax,  32'h7FFF_FFFF, 4'd4,  1'b0, 32'h0, 1'b0},
    '{TolQ,    32'h0009_0000, 4'd2,  1'b0, 32'h0, 1'b0},
    '{TolQ,    32'hC000_0000, 4'd6,  1'b0, 32'h0, 1'b0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [TOL_W-1:0] cfg_wdata_i;

  nrb_in_if  in_if ();
  nrb_out_if out_if ();

  root_t            expected_roots [$];
  logic [TOL_W-1:0] tol_setting;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  int unsigned      hold_left;
  int unsigned      quiet_cycles;
  int unsigned      error_count;

  nth_root_bisection_top #(
    .MaxExponent(MaxExponent),
    .FracBits   (FracBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint fixed_mul_sat(input longint a, input longint b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] prod;
    wa = a;
    wb = b;
    prod = (wa * wb) >>> FracBits;
    if (prod > PowMax) return PowMax;
    if (prod < PowMin) return PowMin;
    return prod[63:0];
  endfunction

  function automatic root_t predict_root(input logic signed [RAD_W-1:0] radicand,
                                         input logic [EXP_W-1:0] exponent);
    longint      x;
    longint      bound;
    longint      lo;
    longint      hi;
    longint      mid;
    longint      tol;
    longint      power;
    int unsigned n;
    root_t       res;
    x = radicand;
    bound = (x < 0) ? -x : x;
    if (bound < FixedOne) bound = FixedOne;
    lo = -bound;
    hi = bound;
    mid = 0;
    tol = (tol_setting == 0) ? longint'(1) : longint'(tol_setting);
    n = (exponent > MaxExponent) ? MaxExponent : exponent;
    while (hi - lo > tol) begin
      mid = (lo + hi) >>> 1;
      power = FixedOne;
      for (int unsigned i = 0; i < n; i++) power = fixed_mul_sat(power, mid);
      if (power < x) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    res.root_value = mid[RAD_W-1:0];
    res.no_real_root = (x < 0) && !n[0];
    return res;
  endfunction

  function automatic logic signed [RAD_W-1:0] pick_radicand();
    logic signed [RAD_W-1:0] v;
    radicand_shape_e         shape;
    shape = radicand_shape_e'($urandom_range(3));
    case (shape)
      SHAPE_FULL: begin
        v = $urandom;
      end
      SHAPE_SMALL: begin
        v = $urandom_range(32'h0010_0000);
      end
      SHAPE_WHOLE: begin
        v = $urandom_range(255) << FracBits;
      end
      default: begin
        v = EdgeValues[$urandom_range(3)];
      end
    endcase
    if (shape != SHAPE_FULL && $urandom_range(1) == 1) v = -v;
    return v;
  endfunction

  function automatic logic [EXP_W-1:0] pick_exponent();
    if ($urandom_range(99) < 80) return EXP_W'($urandom_range(4, 1));
    return EXP_W'($urandom_range(15));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic drive_item(input logic signed [RAD_W-1:0] radicand,
                            input logic [EXP_W-1:0] exponent,
                            input logic use_given, input root_t given);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.radicand <= radicand;
    in_if.exponent <= exponent;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_roots.push_back(use_given ? given : predict_root(radicand, exponent));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (expected_roots.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    drain_results();
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    tol_setting = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    root_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_roots.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, root_value %h no_real_root %b", $time,
                 out_if.root_value, out_if.no_real_root);
      end else begin
        want = expected_roots.pop_front();
        if (out_if.root_value !== want.root_value) begin
          error_count++;
          $display("%0t: root_value expected %h, got %h", $time, want.root_value,
                   out_if.root_value);
        end
        if (out_if.no_real_root !== want.no_real_root) begin
          error_count++;
          $display("%0t: no_real_root expected %b, got %b", $time, want.no_real_root,
                   out_if.no_real_root);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, StallLimit);
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [TOL_W-1:0] tol_pick;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_if.valid    = 1'b0;
    in_if.radicand = '0;
    in_if.exponent = '0;
    out_if.ready   = 1'b0;
    tol_setting    = TolOne;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    error_count    = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].tol != tol_setting) write_tolerance(directed_rows[i].tol);
      drive_item(directed_rows[i].radicand, directed_rows[i].exponent, directed_rows[i].typed,
                 {directed_rows[i].root, directed_rows[i].no_root});
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0, 2, 6: tol_pick = TolOne;
        3:       tol_pick = TolMax;
        5:       tol_pick = TOL_W'($urandom_range(32'h7FFF_FFFF, 1));
        default: tol_pick = TOL_W'($urandom_range(32'h0000_FFFF, 2));
      endcase
      write_tolerance(tol_pick);
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 83;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 83;
        end
        default: begin
          send_idle_pct  = 28;
          recv_stall_pct = 28;
        end
      endcase
      if (phase == 0) begin
        @(posedge clk_i);
        hold_left = HoldOffCycles;
        @(negedge clk_i);
      end
      repeat (PhaseItems) drive_item(pick_radicand(), pick_exponent(), 1'b0, '0);
    end

    drain_results();
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/nrb_pkg.sv
rtl/core/nrb_if.sv
rtl/core/nrb_sequencer.sv
rtl/core/nth_root_bisection_top.sv
dv/testbench.sv
